/* hdl/mi3_pkg.sv */
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int ELEM_W = 32;   // matrix element, signed fixed point
  localparam int N_ELEM = 9;    // elements per matrix, row-major
  localparam int PROD_W = 64;   // 32x32 minor product
  localparam int COF_W  = 65;   // signed cofactor (difference of two products)
  localparam int MAG_W  = 64;   // cofactor magnitude
  localparam int DET_W  = 98;   // exact signed determinant
  localparam int DMAG_W = 97;   // determinant magnitude
  localparam int Q_W    = 32;   // quotient bits resolved by each divider lane

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic [3:0]               idx_t;

  // Determinant summary handed from the determinant pipe to the lanes
  typedef struct packed {
    logic [DMAG_W-1:0] mag;
    logic              neg;
    logic              zero;
  } det_info_t;

  // Raw quotient and flags leaving one divider lane
  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
  } lane_res_t;

  // Adjugate element i = a[MA]*a[MB] - a[MC]*a[MD], negated where COF_NEG is set
  localparam idx_t MA [N_ELEM] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam idx_t MB [N_ELEM] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam idx_t MC [N_ELEM] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
  localparam idx_t MD [N_ELEM] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
  localparam logic COF_NEG [N_ELEM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

endpackage

/* hdl/mi3_cof.sv */
// Two-stage adjugate: registered 2x2 minor products, then signed cofactors.
module mi3_cof (
  input  logic             clk,
  input  logic             en,
  input  mi3_pkg::elem_t   a   [mi3_pkg::N_ELEM],
  output mi3_pkg::cof_t    cof [mi3_pkg::N_ELEM]
);

  logic signed [mi3_pkg::PROD_W-1:0] p_r [mi3_pkg::N_ELEM];
  logic signed [mi3_pkg::PROD_W-1:0] n_r [mi3_pkg::N_ELEM];
  mi3_pkg::cof_t                     cof_r [mi3_pkg::N_ELEM];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        p_r[i] <= a[mi3_pkg::MA[i]] * a[mi3_pkg::MB[i]];
        n_r[i] <= a[mi3_pkg::MC[i]] * a[mi3_pkg::MD[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
        if (mi3_pkg::COF_NEG[i]) begin
          cof_r[i] <= mi3_pkg::COF_W'(n_r[i]) - mi3_pkg::COF_W'(p_r[i]);
        end else begin
          cof_r[i] <= mi3_pkg::COF_W'(p_r[i]) - mi3_pkg::COF_W'(n_r[i]);
        end
      end
    end
  end

  assign cof = cof_r;

endmodule

/* hdl/mi3_det.sv */
// Three-stage determinant: split partial products, exact sum, magnitude and sign.
module mi3_det (
  input  logic                  clk,
  input  logic                  en,
  input  mi3_pkg::elem_t        row0 [3],
  input  mi3_pkg::cof_t         col0 [3],
  output mi3_pkg::det_info_t    info
);

  logic signed [64:0]                plo_r [3];
  logic signed [64:0]                phi_r [3];
  logic signed [mi3_pkg::DET_W-1:0]  det_r;
  logic signed [mi3_pkg::DET_W-1:0]  det_nxt;
  mi3_pkg::det_info_t                info_r;

  // Split each 65-bit cofactor into a low unsigned and a high signed half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= row0[j] * $signed({1'b0, col0[j][31:0]});
        phi_r[j] <= row0[j] * $signed(col0[j][64:32]);
      end
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (mi3_pkg::DET_W'(phi_r[j]) <<< 32) + mi3_pkg::DET_W'(plo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r.neg  <= det_r[mi3_pkg::DET_W-1];
      info_r.zero <= (det_r == '0);
      info_r.mag  <= det_r[mi3_pkg::DET_W-1] ? mi3_pkg::DMAG_W'(-det_r)
                                             : mi3_pkg::DMAG_W'(det_r);
    end
  end

  assign info = info_r;

endmodule

/* hdl/mi3_lane.sv */
// One divider lane: overflow check, then one restoring quotient bit per stage.
module mi3_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mi3_pkg::MAG_W-1:0]     mag,
  input  logic                          neg,
  input  logic [mi3_pkg::DMAG_W-1:0]    d [mi3_pkg::Q_W+1],
  output mi3_pkg::lane_res_t            res
);

  localparam int NW = mi3_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int QW = mi3_pkg::Q_W;

  logic [NW-1:0]                num;
  logic [mi3_pkg::DMAG_W-1:0]   r0;
  logic [mi3_pkg::DMAG_W-1:0]   r_r   [QW];
  logic [QW-1:0]                lo_r  [QW];
  logic [QW-1:0]                q_r   [QW+1];
  logic                         ovf_r [QW+1];
  logic                         neg_r [QW+1];

  assign num = {mag, {(2 * FRAC_BITS){1'b0}}};
  assign r0  = mi3_pkg::DMAG_W'(num[NW-1:QW]);

  // Quotient of 2^32 or more saturates; flag it up front
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= r0;
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (r0 >= d[0]);
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [mi3_pkg::DMAG_W:0] sh;
    logic                     ge;
    assign sh = {r_r[k-1], lo_r[k-1][QW-1]};
    assign ge = (sh >= {1'b0, d[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k]  <= ge ? mi3_pkg::DMAG_W'(sh - {1'b0, d[k]}) : sh[mi3_pkg::DMAG_W-1:0];
          lo_r[k] <= {lo_r[k-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign res.q   = q_r[QW];
  assign res.ovf = ovf_r[QW];
  assign res.neg = neg_r[QW];

endmodule

/* hdl/matrix_inverse_3x3.sv */
// Top level: pipelined 3x3 matrix inverse by the adjugate, nine divider lanes.
//
// Takes one 3x3 signed fixed-point matrix per word and returns its inverse, its
// determinant and a singular flag. Minors, adjugate and determinant are exact;
// each inverse element is adjugate / determinant truncated toward zero and
// saturated to 32 bits, and the determinant is scaled back and saturated.
// A zero determinant raises out_tuser and forces every output field to zero.
// The block is a fully pipelined stream: it accepts a new word every clock while
// the output is not stalled. The word passes 40 register stages (1 input
// register, loaded at the accepting edge, 2 adjugate stages, 3 determinant
// stages, 33 divider stages, 1 output register). The divider depth dominates
// the latency: each of the nine lanes resolves one quotient bit per stage. A
// stalled output freezes the whole pipe, so in_tready follows out_tready while
// a result is waiting. No state is kept between words.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // inv_r0c0 .. inv_r2c2 (32 bits each, row-major), det_value (32 bits)
  output logic [319:0] out_tdata,
  // singular
  output logic         out_tuser
);

  localparam int NE  = mi3_pkg::N_ELEM;
  localparam int QW  = mi3_pkg::Q_W;
  localparam int LAT = 6 + QW + 2;

  logic                         en;
  logic [LAT-1:0]               vld_r;

  mi3_pkg::elem_t               a_r    [NE];
  mi3_pkg::elem_t               row1_r [3];
  mi3_pkg::elem_t               row2_r [3];
  mi3_pkg::cof_t                cof    [NE];
  mi3_pkg::cof_t                col0   [3];
  mi3_pkg::det_info_t           info;

  logic [mi3_pkg::MAG_W-1:0]    mag_r  [3][NE];
  logic                         sgn_r  [3][NE];

  logic [mi3_pkg::DMAG_W-1:0]   dq     [QW+1];
  logic [mi3_pkg::DMAG_W-1:0]   dq_r   [1:QW];
  logic [QW-1:0]                dv_r   [QW+1];
  logic                         sing_r [QW+1];
  logic [mi3_pkg::DMAG_W-1:0]   dsh;
  logic [QW-1:0]                dv_nxt;

  mi3_pkg::lane_res_t           res    [NE];
  logic [319:0]                 data_r;
  logic [319:0]                 data_nxt;
  logic                         user_r;

  // Advance the pipe unless a finished word is held at the output
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // Input register; carry the top row on for the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NE; i++) begin
        a_r[i] <= in_tdata[i*32 +: 32];
      end
      for (int j = 0; j < 3; j++) begin
        row1_r[j] <= a_r[j];
        row2_r[j] <= row1_r[j];
      end
    end
  end

  mi3_cof u_cof (
    .clk (clk),
    .en  (en),
    .a   (a_r),
    .cof (cof)
  );

  // Top-row cofactors are adjugate column 0
  assign col0[0] = cof[0];
  assign col0[1] = cof[3];
  assign col0[2] = cof[6];

  mi3_det u_det (
    .clk  (clk),
    .en   (en),
    .row0 (row2_r),
    .col0 (col0),
    .info (info)
  );

  // Hold the adjugate magnitudes alongside the determinant pipe
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NE; i++) begin
        sgn_r[0][i] <= cof[i][mi3_pkg::COF_W-1];
        mag_r[0][i] <= cof[i][mi3_pkg::COF_W-1] ? mi3_pkg::MAG_W'(-cof[i])
                                                : mi3_pkg::MAG_W'(cof[i]);
        for (int s = 1; s < 3; s++) begin
          sgn_r[s][i] <= sgn_r[s-1][i];
          mag_r[s][i] <= mag_r[s-1][i];
        end
      end
    end
  end

  // Determinant scaled back to the element format, saturated
  always_comb begin
    dsh = info.mag >> (2 * FRAC_BITS);
    if (info.neg) begin
      dv_nxt = (dsh > mi3_pkg::DMAG_W'(mi3_pkg::SAT_NEG)) ? mi3_pkg::SAT_NEG
                                                          : QW'(-dsh[QW-1:0]);
    end else begin
      dv_nxt = (dsh > mi3_pkg::DMAG_W'(mi3_pkg::SAT_POS)) ? mi3_pkg::SAT_POS
                                                          : dsh[QW-1:0];
    end
  end

  // Divisor and determinant flags travel beside the lane stages
  assign dq[0] = info.mag;
  for (genvar k = 1; k <= QW; k++) begin : g_dq
    assign dq[k] = dq_r[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[1]   <= dq[0];
      dv_r[0]   <= dv_nxt;
      sing_r[0] <= info.zero;
      for (int k = 2; k <= QW; k++) begin
        dq_r[k] <= dq_r[k-1];
      end
      for (int k = 1; k <= QW; k++) begin
        dv_r[k]   <= dv_r[k-1];
        sing_r[k] <= sing_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < NE; i++) begin : g_lane
    mi3_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .mag (mag_r[2][i]),
      .neg (sgn_r[2][i] ^ info.neg),
      .d   (dq),
      .res (res[i])
    );
  end

  // Merge: saturate and sign each lane, drop everything on a singular matrix
  always_comb begin
    data_nxt = '0;
    for (int i = 0; i < NE; i++) begin
      if (sing_r[QW]) begin
        data_nxt[i*32 +: 32] = '0;
      end else if (res[i].neg) begin
        data_nxt[i*32 +: 32] = (res[i].ovf || res[i].q > mi3_pkg::SAT_NEG) ?
                               mi3_pkg::SAT_NEG : QW'(-res[i].q);
      end else begin
        data_nxt[i*32 +: 32] = (res[i].ovf || res[i].q > mi3_pkg::SAT_POS) ?
                               mi3_pkg::SAT_POS : res[i].q;
      end
    end
    data_nxt[NE*32 +: 32] = sing_r[QW] ? '0 : dv_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      user_r <= sing_r[QW];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

  // A singular word carries nothing but zeros
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("singular word with nonzero payload");

  // Reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid word after reset");

  // Singular flag and divisor line stay aligned at the last lane stage
  a_det_align: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-3] |-> sing_r[QW-1] == (dq[QW] == '0))
    else $error("singular flag out of step with divisor");

endmodule
